/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL.
// ASSERT_CLK checks a property at every rising clock edge outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* rtl/core/dipa_pkg.sv */
package dipa_pkg;

   // parse phase within the current string
   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_ZERO   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   // number base of the current part
   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_OCT = 2'd1,
      RX_HEX = 2'd2
   } radix_type;

   localparam int unsigned LEAD_PARTS = 3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_HIGH_X = 8'h58;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_HIGH_A = 8'h41;
   localparam logic [7:0] CH_HIGH_F = 8'h46;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

endpackage

/* rtl/core/dotted_ipv4_address_parser.sv */
// Streaming dotted IPv4 address parser with the classic address-text rules.
// One character word is taken every cycle; each word updates the parse
// state in a single pass of logic, and the NUL word loads the result
// register, whose word (ok flag and host-order address, first part in bits
// 31:24) is offered on the following cycle. The result register decouples
// the two sides: the next string's characters keep flowing while a result
// waits, and only a NUL word is held back (req_stall) while an earlier
// result is still stalled.
// Parts may be decimal, octal (leading 0, digits 8 and 9 accepted) or hex
// (leading 0x/0X); one whitespace character ends parsing.
module dotted_ipv4_address_parser import dipa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [31:0] rsp_address
);

`include "assert_macros.svh"

   phase_type   phase_ff, phase_in;
   radix_type   radix_ff, radix_in;
   logic [31:0] accum_ff, accum_in;
   logic [1:0]  part_count_ff, part_count_in;
   logic        failed_ff, failed_in;
   logic [7:0]  part_byte_ff [LEAD_PARTS];
   logic        save_part;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [31:0] rsp_address_ff, rsp_address_in;

   logic        req_fire;
   logic        is_nul;
   logic        is_digit;
   logic        is_hex_letter;
   logic        is_space;
   logic [3:0]  digit_val;
   logic [31:0] accum_next;
   logic        fit_ok;
   logic [31:0] lead_bits;

   // hold a NUL word back only while a finished result is stalled
   assign is_nul    = (req_ch == CH_NUL);
   assign req_stall = rsp_valid_ff && rsp_stall && is_nul;
   assign req_fire  = req_valid && !req_stall;

   // classify the character
   always_comb begin
      is_digit      = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
      is_hex_letter = (radix_ff == RX_HEX) &&
                      (((req_ch >= CH_LOW_A) && (req_ch <= CH_LOW_F)) ||
                       ((req_ch >= CH_HIGH_A) && (req_ch <= CH_HIGH_F)));
      is_space      = req_ch inside {[CH_TAB:CH_CR], CH_SPACE};
      digit_val     = is_digit ? req_ch[3:0] : 4'(req_ch[2:0] + 3'd1) + 4'd8;
   end

   // shift-add accumulate by the part's base
   always_comb begin
      case (radix_ff)
         RX_HEX:  accum_next = {accum_ff[27:0], 4'd0} + 32'(digit_val);
         RX_OCT:  accum_next = {accum_ff[28:0], 3'd0} + 32'(digit_val);
         default: accum_next = {accum_ff[28:0], 3'd0} + {accum_ff[30:0], 1'b0}
                               + 32'(digit_val);
      endcase
   end

   // range check of the last part and merge of the leading bytes
   always_comb begin
      case (part_count_ff)
         2'd0: begin
            fit_ok    = 1'b1;
            lead_bits = '0;
         end
         2'd1: begin
            fit_ok    = (accum_ff[31:24] == 8'd0);
            lead_bits = {part_byte_ff[0], 24'd0};
         end
         2'd2: begin
            fit_ok    = (accum_ff[31:16] == 16'd0);
            lead_bits = {part_byte_ff[0], part_byte_ff[1], 16'd0};
         end
         default: begin
            fit_ok    = (accum_ff[31:8] == 24'd0);
            lead_bits = {part_byte_ff[0], part_byte_ff[1], part_byte_ff[2], 8'd0};
         end
      endcase
   end

   // next parse state
   always_comb begin
      phase_in      = phase_ff;
      radix_in      = radix_ff;
      accum_in      = accum_ff;
      part_count_in = part_count_ff;
      failed_in     = failed_ff;
      save_part     = 1'b0;
      if (req_fire) begin
         if (is_nul) begin
            phase_in      = PH_START;
            radix_in      = RX_DEC;
            accum_in      = '0;
            part_count_in = '0;
            failed_in     = 1'b0;
         end else if (!failed_ff) begin
            case (phase_ff)
               PH_START: begin
                  if (!is_digit) begin
                     failed_in = 1'b1;
                  end else if (req_ch == CH_ZERO) begin
                     accum_in = '0;
                     radix_in = RX_OCT;
                     phase_in = PH_ZERO;
                  end else begin
                     accum_in = 32'(digit_val);
                     radix_in = RX_DEC;
                     phase_in = PH_DIGITS;
                  end
               end
               PH_ZERO, PH_DIGITS: begin
                  if ((phase_ff == PH_ZERO) &&
                      ((req_ch == CH_LOW_X) || (req_ch == CH_HIGH_X))) begin
                     radix_in = RX_HEX;
                     phase_in = PH_DIGITS;
                  end else if (is_digit || is_hex_letter) begin
                     accum_in = accum_next;
                     phase_in = PH_DIGITS;
                  end else if (req_ch == CH_DOT) begin
                     // a leading part wider than a byte can never pass
                     if ((part_count_ff == 2'd3) || (accum_ff[31:8] != 24'd0)) begin
                        failed_in = 1'b1;
                     end else begin
                        save_part     = 1'b1;
                        part_count_in = part_count_ff + 2'd1;
                        accum_in      = '0;
                        radix_in      = RX_DEC;
                        phase_in      = PH_START;
                     end
                  end else if (is_space) begin
                     phase_in = PH_DONE;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               default: begin
                  // after the whitespace terminator: drop characters
               end
            endcase
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_address_in = rsp_address_ff;
      if (req_fire && is_nul) begin
         rsp_valid_in   = 1'b1;
         rsp_ok_in      = !failed_ff && (phase_ff != PH_START) && fit_ok;
         rsp_address_in = rsp_ok_in ? (accum_ff | lead_bits) : '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         radix_ff      <= RX_DEC;
         accum_ff      <= '0;
         part_count_ff <= '0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         radix_ff      <= radix_in;
         accum_ff      <= accum_in;
         part_count_ff <= part_count_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      rsp_ok_ff      <= rsp_ok_in;
      rsp_address_ff <= rsp_address_in;
      if (save_part) begin
         part_byte_ff[part_count_ff] <= accum_ff[7:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_address = rsp_address_ff;

   // checks
   `ASSERT_CLK(a_nul_gives_word, clock, reset, (req_fire && is_nul) |=> rsp_valid_ff)
   `ASSERT_CLK(a_nul_clears_state, clock, reset,
      (req_fire && is_nul) |=> (phase_ff == PH_START && part_count_ff == 2'd0 && !failed_ff))
   `ASSERT_NEVER(a_bad_word_zero, clock, reset,
      rsp_valid_ff && !rsp_ok_ff && (rsp_address_ff != 32'd0))

endmodule

/* tb/sv/parse_result_checker.sv */
module parse_result_checker import dipa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_ok,
   input  logic [31:0] rsp_address,
   output int unsigned mismatches,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        ok;
      logic [31:0] address;
   } parse_result_type;

   // results owed by the block, oldest first
   parse_result_type expected_results[$];

   // parse state of the string in flight
   phase_type   ph;
   radix_type   rx;
   logic [31:0] part_value;
   logic [1:0]  parts_done;
   logic [31:0] lead_parts [3];
   logic        parse_err;

   function automatic logic is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void restart_parse();
      ph         = PH_START;
      rx         = RX_DEC;
      part_value = '0;
      parts_done = '0;
      parse_err  = 1'b0;
      foreach (lead_parts[i]) lead_parts[i] = '0;
   endfunction

   // Advance a part that has already begun by one character.
   function automatic void take_part_char(logic [7:0] c);
      logic [31:0] base;
      if (is_digit(c)) begin
         base       = (rx == RX_HEX) ? 32'd16 : ((rx == RX_OCT) ? 32'd8 : 32'd10);
         part_value = part_value * base + 32'(c - CH_ZERO);
         ph         = PH_DIGITS;
      end else if (rx == RX_HEX && c >= CH_LOW_A && c <= CH_LOW_F) begin
         part_value = {part_value[27:0], 4'(c - CH_LOW_A + 8'd10)};
         ph         = PH_DIGITS;
      end else if (rx == RX_HEX && c >= CH_HIGH_A && c <= CH_HIGH_F) begin
         part_value = {part_value[27:0], 4'(c - CH_HIGH_A + 8'd10)};
         ph         = PH_DIGITS;
      end else if (c == CH_DOT) begin
         // a dot after three finished parts would open a fifth
         if (parts_done >= LEAD_PARTS) begin
            parse_err = 1'b1;
         end else begin
            lead_parts[parts_done] = part_value;
            parts_done             = parts_done + 2'd1;
            part_value             = '0;
            rx                     = RX_DEC;
            ph                     = PH_START;
         end
      end else if (is_blank(c)) begin
         ph = PH_DONE;
      end else begin
         parse_err = 1'b1;
      end
   endfunction

   // Combine the parts and apply the range check of each layout.
   function automatic parse_result_type finish_string();
      parse_result_type res;
      logic             good;
      logic [31:0]      v;
      good = !parse_err && ph != PH_START;
      v    = part_value;
      if (good) begin
         case (parts_done)
            2'd0: ;
            2'd1: begin
               if (v > 32'h00ff_ffff || lead_parts[0] > 32'hff) good = 1'b0;
               else v = v | (lead_parts[0] << 24);
            end
            2'd2: begin
               if (v > 32'h0000_ffff || lead_parts[0] > 32'hff || lead_parts[1] > 32'hff)
                  good = 1'b0;
               else v = v | (lead_parts[0] << 24) | (lead_parts[1] << 16);
            end
            default: begin
               if (v > 32'hff || lead_parts[0] > 32'hff || lead_parts[1] > 32'hff ||
                   lead_parts[2] > 32'hff)
                  good = 1'b0;
               else v = v | (lead_parts[0] << 24) | (lead_parts[1] << 16) | (lead_parts[2] << 8);
            end
         endcase
      end
      res.ok      = good;
      res.address = good ? v : '0;
      return res;
   endfunction

   // Fold one accepted character word into the parse state.
   function automatic void absorb_char(logic [7:0] c);
      if (c == CH_NUL) begin
         expected_results.push_back(finish_string());
         restart_parse();
      end else if (!parse_err && ph != PH_DONE) begin
         case (ph)
            PH_START: begin
               if (!is_digit(c)) begin
                  parse_err = 1'b1;
               end else if (c == CH_ZERO) begin
                  part_value = '0;
                  rx         = RX_OCT;
                  ph         = PH_ZERO;
               end else begin
                  part_value = 32'(c - CH_ZERO);
                  rx         = RX_DEC;
                  ph         = PH_DIGITS;
               end
            end
            PH_ZERO: begin
               if (c == CH_LOW_X || c == CH_HIGH_X) begin
                  rx = RX_HEX;
                  ph = PH_DIGITS;
               end else begin
                  take_part_char(c);
               end
            end
            PH_DIGITS: take_part_char(c);
            default:   parse_err = 1'b1;
         endcase
      end
   endfunction

   task automatic note_mismatch(string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   // Predict on each accepted character word, compare each accepted result word.
   always @(posedge clock) begin
      parse_result_type want;
      if (reset) begin
         restart_parse();
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) absorb_char(req_ch);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               note_mismatch($sformatf("result with nothing pending: ok=%0b address=%08h",
                                       rsp_ok, rsp_address));
            end else begin
               want = expected_results.pop_front();
               if (rsp_ok !== want.ok)
                  note_mismatch($sformatf("ok is %0b, predicted %0b", rsp_ok, want.ok));
               if (rsp_address !== want.address)
                  note_mismatch($sformatf("address is %08h, predicted %08h",
                                          rsp_address, want.address));
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

/* tb/sv/testbench.sv */
module testbench import dipa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch    = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic [31:0] rsp_address;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned words_sent = 0;
   int unsigned stall_left = 0;
   logic        calm       = 1'b0;

   // characters of the string being built, without its NUL
   logic [7:0]  line_buf[$];

   dotted_ipv4_address_parser DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_ch      (req_ch),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_ok      (rsp_ok),
      .rsp_address (rsp_address)
   );

   parse_result_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_ch      (req_ch),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_ok      (rsp_ok),
      .rsp_address (rsp_address),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short idle runs, now and then a long one; none while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Hold off result words in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= !calm && $urandom_range(0, 2) == 0;
         stall_left <= pick_gap();
      end
   end

   task automatic send_word(logic [7:0] c);
      int gap;
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (req_stall);
      words_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_ch    <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_word(line_buf[i]);
      send_word(CH_NUL);
      line_buf.delete();
   endtask

   task automatic push_str(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic put_digits(logic [31:0] v, int unsigned base);
      logic [7:0]  digits[$];
      logic [31:0] d;
      do begin
         d = v % base;
         if (d < 10) digits.push_front(CH_ZERO + 8'(d));
         else digits.push_front(($urandom_range(0, 1) ? CH_LOW_A : CH_HIGH_A) + 8'(d - 10));
         v = v / base;
      end while (v != 0);
      line_buf = {line_buf, digits};
   endtask

   // Render one part in a random base, with the octal and hex oddities mixed in.
   task automatic put_part(logic [31:0] v);
      int unsigned style;
      style = $urandom_range(0, 9);
      if (style < 4) begin
         put_digits(v, 10);
      end else if (style < 7) begin
         line_buf.push_back(CH_ZERO);
         if (v != 0) put_digits(v, 8);
         if ($urandom_range(0, 7) == 0)
            line_buf.push_back($urandom_range(0, 1) ? CH_NINE : CH_NINE - 8'd1);
      end else if (style < 9) begin
         line_buf.push_back(CH_ZERO);
         line_buf.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_HIGH_X);
         if (v != 0 || $urandom_range(0, 1)) begin
            repeat ($urandom_range(0, 2)) line_buf.push_back(CH_ZERO);
            put_digits(v, 16);
         end
      end else begin
         // long decimal run that can wrap past 32 bits
         line_buf.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
         repeat ($urandom_range(8, 14)) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
   endtask

   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 5))
         0:       return CH_ZERO + 8'($urandom_range(0, 9));
         1:       return CH_DOT;
         2:       return $urandom_range(0, 1) ? CH_LOW_X : CH_HIGH_X;
         3:       return ($urandom_range(0, 1) ? CH_LOW_A : CH_HIGH_A) + 8'($urandom_range(0, 5));
         4:       return CH_SPACE;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic make_random_line();
      int unsigned n;
      int unsigned pick;
      logic [31:0] lim;
      logic [31:0] v;
      int unsigned b;
      if ($urandom_range(0, 99) < 80) begin
         // well-formed address with random parts, sometimes out of range
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            if (i != 0) line_buf.push_back(CH_DOT);
            lim  = (i < n - 1) ? 32'hff : (32'hffff_ffff >> (8 * (n - 1)));
            pick = $urandom_range(0, 9);
            if (pick == 0 && lim != 32'hffff_ffff) v = lim + 1 + $urandom_range(0, 255);
            else if (pick == 1) v = lim;
            else if (pick == 2) v = '0;
            else v = (lim == 32'hffff_ffff) ? $urandom : $urandom_range(0, lim);
            put_part(v);
         end
         // sometimes append a tail: blank plus ignored junk, a random character, or an extra part
         case ($urandom_range(0, 9))
            6, 7: begin
               b = $urandom_range(0, 5);
               line_buf.push_back(b == 0 ? CH_SPACE : CH_TAB + 8'(b - 1));
               repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(1, 255)));
            end
            8: begin
               line_buf.push_back(8'($urandom_range(1, 255)));
               repeat ($urandom_range(0, 2)) line_buf.push_back(noise_char());
            end
            9: begin
               line_buf.push_back(CH_DOT);
               if ($urandom_range(0, 1)) put_part($urandom_range(0, 300));
            end
            default: ;
         endcase
      end else begin
         repeat ($urandom_range(0, 8)) line_buf.push_back(noise_char());
      end
   endtask

   initial begin
      int unsigned first_random;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed strings
      send_line();                                   // empty string
      push_str("1.");        send_line();            // trailing dot
      push_str("0x");        send_line();            // bare hex prefix
      push_str("0377.0XfF.255.9\t");                 // all bases, blank end
      line_buf.push_back(8'hff);
      push_str("q");         send_line();
      push_str("1a");        send_line();            // stray trailing letter
      push_str("9");
      line_buf.push_back(8'h80); send_line();        // high byte
      push_str("1.2.3.4.5"); send_line();            // fifth part
      push_str("256.1");     send_line();            // range failure
      push_str("089.0");     send_line();            // octal taking 8 and 9
      push_str("4294967296"); send_line();           // wraps to zero

      // random strings, calm stretches switched on and off
      first_random = words_sent;
      while (words_sent - first_random < 500) begin
         if ($urandom_range(0, 7) == 0) calm = !calm;
         make_random_line();
         send_line();
      end
      req_valid <= 1'b0;

      // drain the results, then let the block settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule

/* dotted_ipv4_address_parser.f */
+incdir+rtl/core
rtl/core/dipa_pkg.sv
rtl/core/dotted_ipv4_address_parser.sv
tb/sv/parse_result_checker.sv
tb/sv/testbench.sv
